>>> src/clbw_pkg.sv
package clbw_pkg;

  localparam int unsigned CLBW_QUEUE_DEPTH = 2;

  localparam int unsigned BUS_W  = 8;
  localparam int unsigned HOLD_W = 11;
  localparam int unsigned STEP_W = 3;

  localparam logic [HOLD_W-1:0] HOLD_STROBE_US = 11'd1;
  localparam logic [HOLD_W-1:0] HOLD_AFTER_US  = 11'd100;
  localparam logic [HOLD_W-1:0] HOLD_SETTLE_US = 11'd50;
  localparam logic [HOLD_W-1:0] HOLD_LONG_US   = 11'd2000;

  localparam logic [BUS_W-1:0] CMD_CLEAR = 8'h01;
  localparam logic [BUS_W-1:0] CMD_HOME  = 8'h02;

  // Register indexes on the configuration port
  localparam logic REG_BUS_IS_8BIT  = 1'b0;
  localparam logic REG_RW_LINE_USED = 1'b1;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_NIBBLE = 2'd2
  } kind_e;

  // One classified request, as the sequencer carries it out
  typedef struct packed {
    logic             rs;
    logic             rw;
    logic [BUS_W-1:0] bus_a;
    logic [BUS_W-1:0] bus_b;
    logic             two_strobes;
    logic             settle;
    logic             long_hold;
  } desc_t;

  // One pin-state word
  typedef struct packed {
    logic              reg_select;
    logic              rw_driven_low;
    logic [BUS_W-1:0]  data_bus;
    logic              enable_line;
    logic [HOLD_W-1:0] hold_us;
    logic              last;
  } out_word_t;

endpackage

>>> src/clbw_front.sv
module clbw_front (
  input  logic                        push_i,
  input  logic [1:0]                  kind_i,
  input  logic [clbw_pkg::BUS_W-1:0]  value_i,
  input  logic                        bus_is_8bit_i,
  input  logic                        rw_line_used_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output clbw_pkg::desc_t             desc_o
);
  import clbw_pkg::*;

  logic known;

  always_comb begin
    known              = 1'b1;
    desc_o             = '0;
    desc_o.rw          = rw_line_used_i;
    unique case (kind_i)
      KIND_CMD, KIND_DATA: begin
        desc_o.rs     = (kind_i == KIND_DATA);
        desc_o.settle = 1'b1;
        desc_o.long_hold = (kind_i == KIND_CMD) &&
                           ((value_i == CMD_CLEAR) || (value_i == CMD_HOME));
        if (bus_is_8bit_i) begin
          desc_o.bus_a = value_i;
        end else begin
          desc_o.bus_a       = {value_i[7:4], 4'h0};
          desc_o.bus_b       = {value_i[3:0], 4'h0};
          desc_o.two_strobes = 1'b1;
        end
      end
      KIND_NIBBLE: begin
        desc_o.bus_a = {value_i[3:0], 4'h0};
      end
      default: begin
        // unused kind: accept and drop
        known = 1'b0;
      end
    endcase
  end

  assign q_push_o = push_i && !q_full_i && known;

endmodule

>>> src/clbw_queue.sv
module clbw_queue #(
  parameter int unsigned Depth = clbw_pkg::CLBW_QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  clbw_pkg::desc_t wr_data_i,
  output logic            full_o,
  input  logic            rd_en_i,
  output clbw_pkg::desc_t rd_data_o,
  output logic            empty_o
);
  import clbw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> src/clbw_back.sv
module clbw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  clbw_pkg::desc_t     q_data_i,
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                out_valid_o,
  output clbw_pkg::out_word_t out_word_o,
  output logic                active_o
);
  import clbw_pkg::*;

  desc_t             desc_q, desc_d;
  logic              active_q, active_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;

  logic              slot_free;
  logic              emit;
  logic              is_last;
  logic              settle_ph;
  logic              second;
  logic [STEP_W-1:0] last_idx;
  logic [STEP_W-1:0] step_rel;
  logic [1:0]        phase;
  out_word_t         word;

  always_comb begin
    if (desc_q.two_strobes) begin
      last_idx = STEP_W'(6);
    end else if (desc_q.settle) begin
      last_idx = STEP_W'(3);
    end else begin
      last_idx = STEP_W'(2);
    end
    is_last   = (step_q == last_idx);
    settle_ph = is_last && desc_q.settle;
    second    = desc_q.two_strobes && (step_q >= STEP_W'(3));
    step_rel  = (step_q >= STEP_W'(3)) ? step_q - STEP_W'(3) : step_q;
    phase     = step_rel[1:0];

    word.reg_select    = desc_q.rs;
    word.rw_driven_low = desc_q.rw;
    word.data_bus      = second ? desc_q.bus_b : desc_q.bus_a;
    word.enable_line   = !settle_ph && (phase == 2'd1);
    word.last          = is_last;
    if (settle_ph) begin
      word.hold_us = desc_q.long_hold ? HOLD_LONG_US : HOLD_SETTLE_US;
    end else begin
      word.hold_us = (phase == 2'd2) ? HOLD_AFTER_US : HOLD_STROBE_US;
    end
  end

  assign slot_free = !out_valid_q || pop_i;
  assign emit      = active_q && slot_free;
  assign q_pop_o   = (!active_q || (emit && is_last)) && !q_empty_i;

  always_comb begin
    desc_d      = desc_q;
    active_d    = active_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (q_pop_o) begin
      desc_d   = q_data_i;
      active_d = 1'b1;
      step_d   = '0;
    end else if (emit) begin
      if (is_last) begin
        active_d = 1'b0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
    if (emit) begin
      out_d       = word;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign active_o    = active_q;

endmodule

>>> src/char_lcd_bus_writer.sv
// Character-display bus writer: expands one write request into pin-state words.
// Input side is a queue: present kind_i/value_i with push; a request is taken
// on a clock edge with push high and full low. Kind 3 is taken and dropped.
// Result side is a queue too: while empty is low the oldest pin-state word sits
// on the result ports; pop takes it. Each word gives RS, RW, D7..D0, E and a
// hold time in microseconds; last marks the final word of a request.
// A request yields 3 words (raw nibble), 4 (8-bit write) or 7 (4-bit write).
// A request is queued, then loaded by the sequencer, which registers its words.
// Throughput: one word per cycle while pop takes each word, set by the single
// output register; a short descriptor queue lets new requests come in while
// earlier ones are still being expanded.
// When pop stays low the output word holds, the sequencer stalls, and once the
// queue fills, full rises and pushes are held off.
// Configuration: APB, byte address 0 = bus_is_8bit, 4 = rw_line_used; pready
// is tied high. Registers are sampled when a request is taken, so write them
// only while the block is idle.
// Reset clears both registers, empties the queue and drops any pending word.
module char_lcd_bus_writer #(
  parameter int unsigned QueueDepth = clbw_pkg::CLBW_QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request queue
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   kind_i,
  input  logic [clbw_pkg::BUS_W-1:0]   value_i,
  // result queue
  output logic                         empty,
  input  logic                         pop,
  output logic                         reg_select_o,
  output logic                         rw_driven_low_o,
  output logic [clbw_pkg::BUS_W-1:0]   data_bus_o,
  output logic                         enable_line_o,
  output logic [clbw_pkg::HOLD_W-1:0]  hold_us_o,
  output logic                         last_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import clbw_pkg::*;

  logic      bus_is_8bit_q;
  logic      rw_line_used_q;
  logic      cfg_wr;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  desc_t     q_wdata;
  desc_t     q_rdata;
  logic      out_valid;
  out_word_t out_word;
  logic      back_active;

  // Configuration registers; only paddr[2] picks the register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_is_8bit_q  <= 1'b0;
      rw_line_used_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BUS_IS_8BIT:  bus_is_8bit_q  <= pwdata[0];
        REG_RW_LINE_USED: rw_line_used_q <= pwdata[0];
        default:          bus_is_8bit_q  <= bus_is_8bit_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BUS_IS_8BIT:  prdata = {31'd0, bus_is_8bit_q};
      REG_RW_LINE_USED: prdata = {31'd0, rw_line_used_q};
      default:          prdata = '0;
    endcase
  end

  // Front: classify each request into a descriptor
  clbw_front u_front (
    .push_i         (push),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .bus_is_8bit_i  (bus_is_8bit_q),
    .rw_line_used_i (rw_line_used_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .desc_o         (q_wdata)
  );

  assign full = q_full;

  // Descriptor queue between front and back
  clbw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_push),
    .wr_data_i (q_wdata),
    .full_o    (q_full),
    .rd_en_i   (q_pop),
    .rd_data_o (q_rdata),
    .empty_o   (q_empty)
  );

  // Back: step through the pin states, one word per cycle while pop takes them
  clbw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_word_o  (out_word),
    .active_o    (back_active)
  );

  assign empty           = !out_valid;
  assign reg_select_o    = out_word.reg_select;
  assign rw_driven_low_o = out_word.rw_driven_low;
  assign data_bus_o      = out_word.data_bus;
  assign enable_line_o   = out_word.enable_line;
  assign hold_us_o       = out_word.hold_us;
  assign last_o          = out_word.last;

`ifndef SYNTH
  // An idle sequencer picks up a waiting descriptor on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!back_active && !q_empty) |=> back_active)
    else $error("sequencer did not pick up a queued request");

  // The enable-high word never ends a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && enable_line_o) |-> !last_o)
    else $error("request ended with enable high");

  // After the enable-high word is taken, the falling-edge word follows at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && enable_line_o) |=>
      (!empty && !enable_line_o && (hold_us_o == HOLD_AFTER_US)))
    else $error("enable strobe not followed by its low hold word");
`endif

endmodule
